[rtl/uart_baud_divisor_search_defines.svh]
// Assertion macros shared by the baud divisor search RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef UART_BAUD_DIVISOR_SEARCH_DEFINES_SVH
`define UART_BAUD_DIVISOR_SEARCH_DEFINES_SVH

// same-cycle implication
`define UBDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UBDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ubds_pkg.sv]
// Package for the UART baud divisor search: field widths, constants and
// the request/response structs of the serial divider. No dependencies.
package ubds_pkg;

  localparam int ClkW    = 32;
  localparam int BaudW   = 24;
  localparam int OsrW    = 6;
  localparam int OsrOutW = 5;
  localparam int DivOutW = 13;
  localparam int DivW    = 32;

  localparam logic [ClkW-1:0]    ClkReset      = 32'd24000000;
  localparam logic [DivOutW-1:0] DivMask       = 13'h1fff;
  localparam logic [OsrOutW-1:0] BothEdgeLimit = 5'd6;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/ubds_in_if.sv]
// Input channel: one requested baud rate per beat.
// Depends on ubds_pkg.
interface ubds_in_if;
  logic                       valid;
  logic                       ready;
  logic [ubds_pkg::BaudW-1:0] requested_baud;

  modport source (output valid, output requested_baud, input ready);
  modport sink (input valid, input requested_baud, output ready);
endinterface

[rtl/ubds_out_if.sv]
// Output channel: chosen oversampling ratio, edge mode and divisor per beat.
// Depends on ubds_pkg.
interface ubds_out_if;
  logic                         valid;
  logic                         ready;
  logic [ubds_pkg::OsrOutW-1:0] osr_minus_one;
  logic                         both_edge;
  logic [ubds_pkg::DivOutW-1:0] divisor;

  modport source (output valid, output osr_minus_one, output both_edge, output divisor,
                  input ready);
  modport sink (input valid, input osr_minus_one, input both_edge, input divisor,
                output ready);
endinterface

[rtl/uart_baud_divisor_search.sv]
// UART baud divisor search: per ratio three 32-bit divisions on one shared
// bit-serial divider plus two compare states (S_ADJ, S_PICK).
// A baud of 0 skips the search. One item in flight; the next is accepted in idle.
// Reset (rst, synchronous) clears control and sets clock_hz to 24000000.
`include "uart_baud_divisor_search_defines.svh"

module uart_baud_divisor_search #(
  parameter int OSR_MIN = 4,
  parameter int OSR_MAX = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ubds_pkg::ClkW-1:0] cfg_wr_data,
  ubds_in_if.sink                   req,
  ubds_out_if.source                rsp
);

  localparam int OsrW = ubds_pkg::OsrW;
  localparam int OutW = ubds_pkg::OsrOutW;
  localparam int DW   = ubds_pkg::DivOutW;
  localparam int CW   = ubds_pkg::ClkW;
  localparam int BW   = ubds_pkg::BaudW;
  localparam bit RangeEmpty = (OSR_MIN > OSR_MAX);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV1_GO   = 4'd1;
  localparam logic [3:0] S_DIV1_WAIT = 4'd2;
  localparam logic [3:0] S_DIV2_GO   = 4'd3;
  localparam logic [3:0] S_DIV2_WAIT = 4'd4;
  localparam logic [3:0] S_DIV3_GO   = 4'd5;
  localparam logic [3:0] S_DIV3_WAIT = 4'd6;
  localparam logic [3:0] S_ADJ       = 4'd7;
  localparam logic [3:0] S_PICK      = 4'd8;
  localparam logic [3:0] S_FINISH    = 4'd9;

  logic [3:0]      state;
  logic [CW-1:0]   clock_hz;
  logic [BW-1:0]   baud;
  logic [OsrW-1:0] osr;
  logic [DW-1:0]   cand_div;
  logic [CW-1:0]   cand_err;
  logic [CW-1:0]   alt_err;
  logic [CW-1:0]   best_err;
  logic [OutW-1:0] best_osr;
  logic [DW-1:0]   best_div;
  logic            out_valid;
  logic [OutW-1:0] out_osr;
  logic            out_both;
  logic [DW-1:0]   out_div;

  logic [29:0]     prod1;
  logic [18:0]     prod2;
  logic [DW:0]     div_inc;
  logic [19:0]     prod3;
  logic [CW-1:0]   baud_w;
  logic [DW-1:0]   q_div;
  logic            out_free;

  ubds_pkg::div_req_t div_req;
  ubds_pkg::div_rsp_t div_rsp;

  ubds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign baud_w  = CW'(baud);
  assign prod1   = 30'(baud) * 30'(osr);
  assign prod2   = 19'(osr) * 19'(cand_div);
  assign div_inc = (DW + 1)'(cand_div) + (DW + 1)'(1);
  assign prod3   = 20'(osr) * 20'(div_inc);
  assign q_div   = div_rsp.quotient[DW-1:0];
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    div_req.dividend = clock_hz;
    div_req.divisor  = '0;
    div_req.start    = 1'b0;
    unique case (state)
      S_DIV1_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = CW'(prod1);
      end
      S_DIV2_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = CW'(prod2);
      end
      S_DIV3_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = CW'(prod3);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= ubds_pkg::ClkReset;
    end else if (cfg_wr_en) begin
      clock_hz <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= (req.requested_baud == '0 || RangeEmpty) ? S_FINISH : S_DIV1_GO;
          end
        end
        S_DIV1_GO:   state <= S_DIV1_WAIT;
        S_DIV1_WAIT: if (div_rsp.done) state <= S_DIV2_GO;
        S_DIV2_GO:   state <= S_DIV2_WAIT;
        S_DIV2_WAIT: if (div_rsp.done) state <= S_DIV3_GO;
        S_DIV3_GO:   state <= S_DIV3_WAIT;
        S_DIV3_WAIT: if (div_rsp.done) state <= S_ADJ;
        S_ADJ:       state <= S_PICK;
        S_PICK:      state <= (osr == OsrW'(OSR_MAX)) ? S_FINISH : S_DIV1_GO;
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          baud     <= req.requested_baud;
          best_err <= CW'(req.requested_baud);
          best_osr <= '0;
          best_div <= '0;
          osr      <= OsrW'(OSR_MIN);
        end
      end
      S_DIV1_WAIT: begin
        if (div_rsp.done) cand_div <= (q_div == '0) ? DW'(1) : q_div;
      end
      S_DIV2_WAIT: begin
        if (div_rsp.done) cand_err <= div_rsp.quotient - baud_w;
      end
      S_DIV3_WAIT: begin
        if (div_rsp.done) alt_err <= baud_w - div_rsp.quotient;
      end
      S_ADJ: begin
        if (cand_err > alt_err) begin
          cand_err <= alt_err;
          if (cand_div != ubds_pkg::DivMask) cand_div <= div_inc[DW-1:0];
        end
      end
      S_PICK: begin
        if (cand_err <= best_err) begin
          best_err <= cand_err;
          best_osr <= OutW'(osr - OsrW'(1));
          best_div <= cand_div;
        end
        osr <= osr + OsrW'(1);
      end
      S_FINISH: begin
        if (out_free) begin
          out_osr  <= best_osr;
          out_both <= (baud != '0) && (best_osr <= ubds_pkg::BothEdgeLimit);
          out_div  <= best_div;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.osr_minus_one = out_osr;
  assign rsp.both_edge     = out_both;
  assign rsp.divisor       = out_div;

  `UBDS_ASSERT_NOW(a_start_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `UBDS_ASSERT_NOW(a_osr_range, state == S_PICK,
                   osr >= OsrW'(OSR_MIN) && osr <= OsrW'(OSR_MAX), "ratio out of range")
  `UBDS_ASSERT_NOW(a_div_nonzero, state == S_PICK, cand_div != '0, "candidate divisor is zero")
  `UBDS_ASSERT_NEXT(a_finish_loads, state == S_FINISH && out_free,
                    out_valid && state == S_IDLE, "result not loaded")

endmodule

[rtl/ubds_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ubds_pkg and uart_baud_divisor_search_defines.svh.
`include "uart_baud_divisor_search_defines.svh"

module ubds_div (
  input  logic               clk,
  input  logic               rst,
  input  ubds_pkg::div_req_t req,
  output ubds_pkg::div_rsp_t rsp
);

  localparam int W    = ubds_pkg::DivW;
  localparam int CntW = $clog2(W);

  logic            busy;
  logic            done;
  logic [CntW-1:0] cnt;
  logic [W-1:0]    rem;
  logic [W-1:0]    quo;
  logic [W-1:0]    dvsr;

  logic [W+1:0]    diff;
  logic            fits;

  assign diff = {1'b0, rem, quo[W-1]} - {2'b00, dvsr};
  assign fits = !diff[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (cnt == CntW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CntW'(1);
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= fits ? diff[W-1:0] : {rem[W-2:0], quo[W-1]};
      quo <= {quo[W-2:0], fits};
    end else if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  `UBDS_ASSERT_NEXT(a_start_busy, req.start && !busy, busy, "divider did not start")
  `UBDS_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `UBDS_ASSERT_NOW(a_done_idle, done, !busy, "done while still busy")

endmodule

[sim/tb.sv]
// Testbench for uart_baud_divisor_search: sends requested baud rates under several
// module clock settings and checks each chosen ratio, edge mode and divisor.
// Depends on ubds_pkg, ubds_in_if, ubds_out_if and the block's RTL.
module tb;

  localparam int OSR_MIN       = 4;
  localparam int OSR_MAX       = 32;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [ubds_pkg::OsrOutW-1:0] osr_minus_one;
    logic                         both_edge;
    logic [ubds_pkg::DivOutW-1:0] divisor;
  } baud_setting_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [ubds_pkg::ClkW-1:0] cfg_wr_data = '0;

  ubds_in_if  req_if ();
  ubds_out_if rsp_if ();

  uart_baud_divisor_search #(.OSR_MIN(OSR_MIN), .OSR_MAX(OSR_MAX)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  baud_setting_t             setting_q[$];
  logic [ubds_pkg::ClkW-1:0] clock_hz = ubds_pkg::ClkReset;
  int                        burst_left = 0;
  int                        calm_left = 0;
  int                        stall_left = 0;
  int                        idle_cycles = 0;
  int                        n_requests = 0;
  int                        n_settings = 0;
  int                        n_clocks = 0;
  int                        n_errors = 0;

  always #5 clk = ~clk;

  initial begin
    req_if.valid = 1'b0;
    req_if.requested_baud = '0;
    rsp_if.ready = 1'b0;
  end

  function automatic baud_setting_t predict_setting(input logic [ubds_pkg::BaudW-1:0] baud);
    baud_setting_t res;
    logic [31:0]   rate, best_err, best_osr, best_div, div, err, up_rate, ratio;
    res = '0;
    if (baud == '0) return res;
    rate = 32'(baud);
    best_err = rate;
    best_osr = '0;
    best_div = '0;
    for (int osr = OSR_MIN; osr <= OSR_MAX; osr++) begin
      ratio = 32'(osr);
      div = (clock_hz / (rate * ratio)) & 32'(ubds_pkg::DivMask);
      if (div == '0) div = 32'd1;
      err = clock_hz / (ratio * div) - rate;
      up_rate = clock_hz / (ratio * (div + 32'd1));
      if (err > rate - up_rate) begin
        err = rate - up_rate;
        if (div < 32'(ubds_pkg::DivMask)) div = div + 32'd1;
      end
      if (err <= best_err) begin
        best_err = err;
        best_osr = ratio - 32'd1;
        best_div = div;
      end
    end
    res.osr_minus_one = best_osr[ubds_pkg::OsrOutW-1:0];
    res.both_edge = (best_osr <= 32'(ubds_pkg::BothEdgeLimit));
    res.divisor = best_div[ubds_pkg::DivOutW-1:0];
    return res;
  endfunction

  // Receiver: random stalls, with calm stretches of constant ready.
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      rsp_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      case ($urandom_range(0, 3))
        0: calm_left = $urandom_range(100, 3000);
        1: stall_left = $urandom_range(1, 40);
        default: ;
      endcase
    end
  end

  // Scoreboard and watchdog.
  always @(posedge clk) begin
    baud_setting_t exp_s;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_settings++;
        if (setting_q.size() == 0) begin
          $error("result beat with no request pending");
          n_errors++;
        end else begin
          exp_s = setting_q.pop_front();
          if (rsp_if.osr_minus_one !== exp_s.osr_minus_one) begin
            $error("osr_minus_one: expected %0d, got %0d", exp_s.osr_minus_one,
                   rsp_if.osr_minus_one);
            n_errors++;
          end
          if (rsp_if.both_edge !== exp_s.both_edge) begin
            $error("both_edge: expected %0d, got %0d", exp_s.both_edge, rsp_if.both_edge);
            n_errors++;
          end
          if (rsp_if.divisor !== exp_s.divisor) begin
            $error("divisor: expected %0d, got %0d", exp_s.divisor, rsp_if.divisor);
            n_errors++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        n_requests++;
        setting_q.push_back(predict_setting(req_if.requested_baud));
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no beat for %0d cycles", WatchdogLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_baud(input logic [ubds_pkg::BaudW-1:0] baud);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.requested_baud <= baud;
    do @(posedge clk); while (!req_if.ready);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (setting_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_clock(input logic [ubds_pkg::ClkW-1:0] hz);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    clock_hz = hz;
    n_clocks++;
  endtask

  function automatic logic [ubds_pkg::BaudW-1:0] pick_baud();
    logic [ubds_pkg::BaudW-1:0] b;
    logic [31:0]                q;
    int                         w;
    int                         std_rates[15] = '{300, 1200, 2400, 4800, 9600, 19200, 38400,
                                                  57600, 115200, 230400, 460800, 921600,
                                                  1000000, 3000000, 4000000};
    case ($urandom_range(0, 9))
      0, 1: b = ubds_pkg::BaudW'(std_rates[$urandom_range(0, 14)]);
      2, 3: begin
        w = $urandom_range(1, ubds_pkg::BaudW);
        b = ubds_pkg::BaudW'($urandom) & ubds_pkg::BaudW'((32'd1 << w) - 1);
        b[w-1] = 1'b1;
      end
      4, 5: b = ubds_pkg::BaudW'($urandom);
      6: b = ubds_pkg::BaudW'($urandom_range(0, 64));
      default: begin
        // near an exact clock / (ratio * divisor) to provoke ties
        q = clock_hz / (32'($urandom_range(OSR_MIN, OSR_MAX)) * 32'($urandom_range(1, 8191)));
        q = q + 32'($urandom_range(0, 2)) - 32'd1;
        b = (q > 32'hffffff || q == 0) ? ubds_pkg::BaudW'($urandom_range(1, 1000))
                                       : ubds_pkg::BaudW'(q);
      end
    endcase
    return b;
  endfunction

  function automatic logic [ubds_pkg::ClkW-1:0] pick_clock();
    logic [ubds_pkg::ClkW-1:0] c;
    int                        w;
    case ($urandom_range(0, 4))
      0: c = ubds_pkg::ClkW'($urandom_range(1, 16)) * 32'd8000000;
      1: c = ubds_pkg::ClkW'($urandom);
      2: begin
        w = $urandom_range(1, ubds_pkg::ClkW);
        c = ubds_pkg::ClkW'($urandom) & ubds_pkg::ClkW'((33'd1 << w) - 1);
      end
      3: c = $urandom_range(0, 1) ? ubds_pkg::ClkW'($urandom_range(1, 64))
                                  : ~ubds_pkg::ClkW'($urandom_range(0, 63));
      default: c = ubds_pkg::ClkW'($urandom_range(1000000, 200000000));
    endcase
    if (c == '0) c = 32'd1;
    return c;
  endfunction

  task automatic test_reset_clock();
    logic [ubds_pkg::BaudW-1:0] bauds[9] = '{0, 1, 300, 9600, 115200, 921600, 3000000,
                                             6000000, 24'hffffff};
    foreach (bauds[i]) send_baud(bauds[i]);
    drain();
  endtask

  task automatic test_clock_extremes();
    logic [ubds_pkg::BaudW-1:0] bauds_hi[7] = '{1, 2, 100, 115200, 24'haaaaaa, 24'h555555,
                                                24'hffffff};
    write_clock(32'd1);
    send_baud(24'd1);
    send_baud(24'hffffff);
    send_baud(24'd0);
    drain();
    write_clock(32'hffffffff);
    foreach (bauds_hi[i]) send_baud(bauds_hi[i]);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      write_clock(ph == 0 ? 32'd48000000 : pick_clock());
      repeat (30) send_baud(pick_baud());
      drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_clock();
    test_clock_extremes();
    test_random_phases();
    repeat (20) @(posedge clk);
    $display("Covered %0d baud requests and %0d results over %0d clock writes plus reset clock",
             n_requests, n_settings, n_clocks);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/ubds_pkg.sv
rtl/ubds_in_if.sv
rtl/ubds_out_if.sv
rtl/ubds_div.sv
rtl/uart_baud_divisor_search.sv
sim/tb.sv
